// ===== rtl/core/scl_pkg.sv =====
`default_nettype none

package scl_pkg;

   // Lexer modes. The encoding value 7 is never entered.
   typedef enum logic [2:0] {
      MODE_NAME = 3'd0,
      MODE_WAIT = 3'd1,
      MODE_OPT  = 3'd2,
      MODE_ARG  = 3'd3,
      MODE_IN   = 3'd4,
      MODE_NEW  = 3'd5,
      MODE_APP  = 3'd6
   } mode_type;

   // Result kinds carried on the result channel's tuser.
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Token classes.
   localparam logic [2:0] CLASS_NAME = 3'd0;
   localparam logic [2:0] CLASS_OPT  = 3'd1;
   localparam logic [2:0] CLASS_ARG  = 3'd2;
   localparam logic [2:0] CLASS_IN   = 3'd3;
   localparam logic [2:0] CLASS_NEW  = 3'd4;
   localparam logic [2:0] CLASS_APP  = 3'd5;

   // Characters with a meaning to the lexer.
   localparam logic [7:0] CHAR_LESS    = 8'h3C;
   localparam logic [7:0] CHAR_GREATER = 8'h3E;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;

   // Most results one character can cause.
   localparam int MAX_RESULTS = 3;

   // One buffered result.
   typedef struct packed {
      logic       kind;
      logic [7:0] text;
      logic [2:0] cls;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/shell_command_lexer_unit.sv =====
`default_nettype none

// Shell command lexer. The request channel carries one byte of command-line
// text per beat in req_tdata, with req_tlast set on the last byte of a line.
// The response channel returns token characters and token-complete markers:
// rsp_tdata holds the character and its token class, rsp_tuser tells a
// character (0) from a token-complete marker (1), and rsp_tlast marks the
// last response beat caused by one request byte. A byte may cause no beat
// at all (whitespace between tokens, the second '>' of '>>').
// Each accepted byte is lexed in the cycle it is accepted and its results
// are written into a three-entry result register, so the first response
// beat is offered in the cycle after acceptance. While the receiver does
// not stall, bytes with one result or none let ordinary text stream at one
// byte per cycle; a byte with more results holds the request side while the
// result register drains one entry per beat.
// When the receiver stalls, the result register holds its beat and the
// request side is only ready again in the cycle the last buffered beat
// leaves. Synchronous reset empties the result register and returns the
// lexer to the command-name mode with all flags and counts cleared; the
// same happens to the lexer state after the last byte of every line.
module shell_command_lexer_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] character
   input  wire         req_tlast,   // line end
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] token_char, [10:8] token_class, zero above
   output logic [0:0]  rsp_tuser,   // [0] result_kind
   output logic        rsp_tlast    // run_last
);

   // Lexer state.
   scl_pkg::mode_type mode_ff, mode_in;
   logic              opt_quoted_ff, opt_quoted_in;
   logic              arg_quoted_ff, arg_quoted_in;
   logic [1:0]        tok_len_ff, tok_len_in;
   logic              pend_gt_ff, pend_gt_in;

   // Result register: up to three results of one byte and a read index.
   scl_pkg::result_type res_ff [scl_pkg::MAX_RESULTS];
   scl_pkg::result_type res_in [scl_pkg::MAX_RESULTS];
   logic [1:0]          count_ff, count_in;
   logic [1:0]          idx_ff;

   logic       req_fire;
   logic       rsp_fire;
   logic       on_last_beat;
   logic [7:0] ch;
   logic       last;
   logic       blank;
   logic       is_lt;
   logic       is_gt;
   logic       is_quote;
   logic       is_dash;
   logic       skip;
   logic [1:0] prefix_len;
   logic [2:0] redir_cls;

   assign ch       = req_tdata;
   assign last     = req_tlast;
   assign blank    = (ch == scl_pkg::CHAR_SPACE) ||
                     (ch >= scl_pkg::CHAR_TAB && ch <= scl_pkg::CHAR_CR);
   assign is_lt    = (ch == scl_pkg::CHAR_LESS);
   assign is_gt    = (ch == scl_pkg::CHAR_GREATER);
   assign is_quote = (ch == scl_pkg::CHAR_QUOTE);
   assign is_dash  = (ch == scl_pkg::CHAR_DASH);

   // Handshakes. The request side is ready when the result register is
   // empty or its final entry leaves in this cycle.
   assign rsp_tvalid   = (idx_ff != count_ff);
   assign on_last_beat = (idx_ff == count_ff - 2'd1);
   assign rsp_fire     = rsp_tvalid && rsp_tready;
   assign req_tready   = !rsp_tvalid || (rsp_fire && on_last_beat);
   assign req_fire     = req_tvalid && req_tready;

   assign rsp_tdata = {5'd0, res_ff[idx_ff].cls, res_ff[idx_ff].text};
   assign rsp_tuser = res_ff[idx_ff].kind;
   assign rsp_tlast = on_last_beat;

   // Redirection tokens: class and length of the inserted prefix.
   always_comb begin
      unique case (mode_ff)
         scl_pkg::MODE_IN: begin
            redir_cls  = scl_pkg::CLASS_IN;
            prefix_len = 2'd1;
         end
         scl_pkg::MODE_APP: begin
            redir_cls  = scl_pkg::CLASS_APP;
            prefix_len = 2'd2;
         end
         default: begin
            redir_cls  = scl_pkg::CLASS_NEW;
            prefix_len = 2'd1;
         end
      endcase
   end

   // Lexing of one byte. Results are appended in order at count_in; every
   // appended character bumps the saturating token length and every
   // token-complete marker clears it together with the argument quote flag.
   always_comb begin
      mode_in       = mode_ff;
      opt_quoted_in = opt_quoted_ff;
      arg_quoted_in = arg_quoted_ff;
      tok_len_in    = tok_len_ff;
      pend_gt_in    = pend_gt_ff;
      count_in      = 2'd0;
      skip          = 1'b0;
      for (int i = 0; i < scl_pkg::MAX_RESULTS; i++) begin
         res_in[i] = '{kind: scl_pkg::KIND_CHAR, text: 8'd0, cls: 3'd0};
      end

      // A '>' right after a '>' turns the redirection into append.
      if (pend_gt_ff) begin
         pend_gt_in = 1'b0;
         if (is_gt) begin
            mode_in = scl_pkg::MODE_APP;
            skip    = 1'b1;
         end
      end

      if (!skip) begin
         case (mode_ff)
            scl_pkg::MODE_NAME: begin
               if ((blank && tok_len_ff != 2'd0) || is_lt || is_gt) begin
                  res_in[count_in] = '{scl_pkg::KIND_END, 8'd0, scl_pkg::CLASS_NAME};
                  count_in      = count_in + 2'd1;
                  tok_len_in    = 2'd0;
                  arg_quoted_in = 1'b0;
                  if (blank) begin
                     mode_in = scl_pkg::MODE_WAIT;
                  end else if (is_lt) begin
                     mode_in = scl_pkg::MODE_IN;
                  end else begin
                     mode_in    = scl_pkg::MODE_NEW;
                     pend_gt_in = !last;
                  end
               end else if (!blank) begin
                  res_in[count_in] = '{scl_pkg::KIND_CHAR, ch, scl_pkg::CLASS_NAME};
                  count_in = count_in + 2'd1;
                  if (tok_len_in != 2'd3) tok_len_in = tok_len_in + 2'd1;
               end
            end
            scl_pkg::MODE_WAIT: begin
               if (blank) begin
                  mode_in = scl_pkg::MODE_WAIT;
               end else if (is_dash) begin
                  res_in[count_in] = '{scl_pkg::KIND_CHAR, ch, scl_pkg::CLASS_OPT};
                  count_in = count_in + 2'd1;
                  if (tok_len_in != 2'd3) tok_len_in = tok_len_in + 2'd1;
                  mode_in = scl_pkg::MODE_OPT;
               end else if (is_lt) begin
                  mode_in = scl_pkg::MODE_IN;
               end else if (is_gt) begin
                  mode_in    = scl_pkg::MODE_NEW;
                  pend_gt_in = !last;
               end else begin
                  arg_quoted_in    = is_quote;
                  res_in[count_in] = '{scl_pkg::KIND_CHAR, ch, scl_pkg::CLASS_ARG};
                  count_in = count_in + 2'd1;
                  if (tok_len_in != 2'd3) tok_len_in = tok_len_in + 2'd1;
                  mode_in = scl_pkg::MODE_ARG;
               end
            end
            scl_pkg::MODE_OPT: begin
               if (is_quote) begin
                  opt_quoted_in    = !opt_quoted_ff;
                  res_in[count_in] = '{scl_pkg::KIND_CHAR, ch, scl_pkg::CLASS_OPT};
                  count_in = count_in + 2'd1;
                  if (tok_len_in != 2'd3) tok_len_in = tok_len_in + 2'd1;
               end else if (((blank || is_lt || is_gt) && !opt_quoted_ff) || last) begin
                  // On a last byte other than a quote the option closes and the byte is dropped.
                  res_in[count_in] = '{scl_pkg::KIND_END, 8'd0, scl_pkg::CLASS_OPT};
                  count_in      = count_in + 2'd1;
                  tok_len_in    = 2'd0;
                  arg_quoted_in = 1'b0;
                  if (blank) begin
                     mode_in = scl_pkg::MODE_WAIT;
                  end else if (is_lt) begin
                     mode_in = scl_pkg::MODE_IN;
                  end else if (is_gt) begin
                     mode_in    = scl_pkg::MODE_NEW;
                     pend_gt_in = !last;
                  end
               end else begin
                  res_in[count_in] = '{scl_pkg::KIND_CHAR, ch, scl_pkg::CLASS_OPT};
                  count_in = count_in + 2'd1;
                  if (tok_len_in != 2'd3) tok_len_in = tok_len_in + 2'd1;
               end
            end
            scl_pkg::MODE_ARG: begin
               if (arg_quoted_ff) begin
                  res_in[count_in] = '{scl_pkg::KIND_CHAR, ch, scl_pkg::CLASS_ARG};
                  count_in = count_in + 2'd1;
                  if (tok_len_in != 2'd3) tok_len_in = tok_len_in + 2'd1;
                  if (is_quote || last) begin
                     res_in[count_in] = '{scl_pkg::KIND_END, 8'd0, scl_pkg::CLASS_ARG};
                     count_in      = count_in + 2'd1;
                     tok_len_in    = 2'd0;
                     arg_quoted_in = 1'b0;
                     mode_in       = scl_pkg::MODE_WAIT;
                  end
               end else if (blank || is_lt || is_gt) begin
                  res_in[count_in] = '{scl_pkg::KIND_END, 8'd0, scl_pkg::CLASS_ARG};
                  count_in      = count_in + 2'd1;
                  tok_len_in    = 2'd0;
                  arg_quoted_in = 1'b0;
                  if (blank) begin
                     mode_in = scl_pkg::MODE_WAIT;
                  end else if (is_lt) begin
                     mode_in = scl_pkg::MODE_IN;
                  end else begin
                     mode_in    = scl_pkg::MODE_NEW;
                     pend_gt_in = !last;
                  end
               end else begin
                  res_in[count_in] = '{scl_pkg::KIND_CHAR, ch, scl_pkg::CLASS_ARG};
                  count_in = count_in + 2'd1;
                  if (tok_len_in != 2'd3) tok_len_in = tok_len_in + 2'd1;
               end
            end
            scl_pkg::MODE_IN, scl_pkg::MODE_NEW, scl_pkg::MODE_APP: begin
               // The first byte of a redirection first inserts its prefix.
               if (tok_len_ff == 2'd0) begin
                  res_in[count_in] = '{scl_pkg::KIND_CHAR,
                                       (mode_ff == scl_pkg::MODE_IN) ?
                                       scl_pkg::CHAR_LESS : scl_pkg::CHAR_GREATER,
                                       redir_cls};
                  count_in   = count_in + 2'd1;
                  tok_len_in = 2'd1;
                  if (prefix_len == 2'd2) begin
                     res_in[count_in] = '{scl_pkg::KIND_CHAR, scl_pkg::CHAR_GREATER,
                                          redir_cls};
                     count_in   = count_in + 2'd1;
                     tok_len_in = 2'd2;
                  end
               end
               if ((blank && (tok_len_in > prefix_len || last)) || is_lt || is_gt) begin
                  res_in[count_in] = '{scl_pkg::KIND_END, 8'd0, redir_cls};
                  count_in      = count_in + 2'd1;
                  tok_len_in    = 2'd0;
                  arg_quoted_in = 1'b0;
                  if (blank) begin
                     mode_in = scl_pkg::MODE_WAIT;
                  end else if (is_lt) begin
                     mode_in = scl_pkg::MODE_IN;
                  end else begin
                     mode_in    = scl_pkg::MODE_NEW;
                     pend_gt_in = !last;
                  end
               end else if (!blank) begin
                  res_in[count_in] = '{scl_pkg::KIND_CHAR, ch, redir_cls};
                  count_in = count_in + 2'd1;
                  if (tok_len_in != 2'd3) tok_len_in = tok_len_in + 2'd1;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end

      // The end of a line returns the lexer to its reset state.
      if (last) begin
         mode_in       = scl_pkg::MODE_NAME;
         opt_quoted_in = 1'b0;
         arg_quoted_in = 1'b0;
         tok_len_in    = 2'd0;
         pend_gt_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= scl_pkg::MODE_NAME;
         opt_quoted_ff <= 1'b0;
         arg_quoted_ff <= 1'b0;
         tok_len_ff    <= 2'd0;
         pend_gt_ff    <= 1'b0;
         count_ff      <= 2'd0;
         idx_ff        <= 2'd0;
      end else begin
         if (req_fire) begin
            mode_ff       <= mode_in;
            opt_quoted_ff <= opt_quoted_in;
            arg_quoted_ff <= arg_quoted_in;
            tok_len_ff    <= tok_len_in;
            pend_gt_ff    <= pend_gt_in;
            count_ff      <= count_in;
            idx_ff        <= 2'd0;
         end else if (rsp_fire) begin
            if (on_last_beat) begin
               count_ff <= 2'd0;
               idx_ff   <= 2'd0;
            end else begin
               idx_ff <= idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < scl_pkg::MAX_RESULTS; i++) begin
            res_ff[i] <= res_in[i];
         end
      end
   end

`ifndef SYNTHESIS
   // An append lookahead is only pending right after a '>' opened output new.
   a_pend_gt_mode: assert property (@(posedge clock) disable iff (reset)
      pend_gt_ff |-> mode_ff == scl_pkg::MODE_NEW)
      else $error("pending '>' outside output-new mode");

   // A quoted argument flag lives only inside an argument.
   a_arg_quoted_mode: assert property (@(posedge clock) disable iff (reset)
      arg_quoted_ff |-> mode_ff == scl_pkg::MODE_ARG)
      else $error("argument quote flag set outside argument mode");

   // Between tokens no characters are counted.
   a_wait_empty: assert property (@(posedge clock) disable iff (reset)
      mode_ff == scl_pkg::MODE_WAIT |-> tok_len_ff == 2'd0)
      else $error("token length nonzero while waiting");

   // A token-complete beat never carries a character.
   a_end_no_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] == scl_pkg::KIND_END) |-> rsp_tdata[7:0] == 8'd0)
      else $error("token-complete beat with a character");
`endif

endmodule

`default_nettype wire
